[hw/rtl/mcv_pkg.sv]
// mcv_pkg: sizes, types and state codes for the multichannel valid convolution
// shared by mcv_cell and multichannel_valid_conv2d; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mcv_pkg;

  localparam int MAX_IMAGE    = 64;
  localparam int MAX_KERNEL   = 7;
  localparam int MAX_CHANNELS = 4;

  localparam int LINE_DEPTH = MAX_KERNEL * MAX_IMAGE;   // per channel
  localparam int WT_DEPTH   = MAX_KERNEL * MAX_KERNEL;  // per channel
  localparam int LADDR_W    = $clog2(LINE_DEPTH);
  localparam int WADDR_W    = $clog2(WT_DEPTH);
  localparam int COL_W      = $clog2(MAX_IMAGE);
  localparam int SLOT_W     = $clog2(MAX_KERNEL);
  localparam int CHI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NREG_W     = 7;
  localparam int KREG_W     = 3;
  localparam int CREG_W     = 3;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + $clog2(MAX_CHANNELS) + 1;
  localparam int ACC_W      = SUM_W + $clog2(WT_DEPTH) + 1;
  localparam int CONV_W     = 48;

  // register indexes of the configuration port
  localparam logic [1:0] REG_IMAGE   = 2'd0;
  localparam logic [1:0] REG_KERNEL  = 2'd1;
  localparam logic [1:0] REG_CHANNEL = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} mcv_state_t;

  // store writes into one cell
  typedef struct packed {
    logic                     line_we;
    logic [LADDR_W-1:0]       laddr;
    logic                     wt_we;
    logic [WADDR_W-1:0]       waddr;
    logic signed [DATA_W-1:0] data;
  } mcv_wr_t;

  // window read request passed along the chain
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [LADDR_W-1:0] laddr;
    logic [WADDR_W-1:0] waddr;
  } mcv_rd_t;

  // partial sum across channels passed along the chain
  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic signed [SUM_W-1:0] sum;
  } mcv_sum_t;

endpackage
`default_nettype wire

[hw/rtl/mcv_cell.sv]
// mcv_cell: one channel of the chain; holds that channel's line and weight store,
// multiplies one tap and adds it to the neighbor's partial sum; uses mcv_pkg
`timescale 1ns / 1ps
`default_nettype none
module mcv_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mcv_pkg::mcv_wr_t wr,
  input  wire logic             active,
  input  wire mcv_pkg::mcv_rd_t rd_in,
  output mcv_pkg::mcv_rd_t      rd_out,
  input  wire mcv_pkg::mcv_sum_t psum_in,
  output mcv_pkg::mcv_sum_t     psum_out
);

  logic signed [mcv_pkg::DATA_W-1:0] line_mem [mcv_pkg::LINE_DEPTH];
  logic signed [mcv_pkg::DATA_W-1:0] wt_mem [mcv_pkg::WT_DEPTH];
  logic signed [mcv_pkg::DATA_W-1:0] ls_q;
  logic signed [mcv_pkg::DATA_W-1:0] ws_q;
  logic signed [mcv_pkg::PROD_W-1:0] prod;
  logic                              act_q;
  logic [2:0]                        tag1;
  logic [2:0]                        tag2;

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (wr.line_we) line_mem[wr.laddr] <= wr.data;
    if (wr.wt_we) wt_mem[wr.waddr] <= wr.data;
    ls_q  <= line_mem[rd_in.laddr];
    ws_q  <= wt_mem[rd_in.waddr];
    act_q <= active;
  end

  // product, partial sum from the left, and the request handed to the next channel
  always_ff @(posedge clk) begin
    prod <= act_q ? ls_q * ws_q : mcv_pkg::PROD_W'(0);
    psum_out.sum <= psum_in.sum + mcv_pkg::SUM_W'(prod);
    psum_out.first <= tag2[1];
    psum_out.last  <= tag2[0];
    rd_out.first <= rd_in.first;
    rd_out.last  <= rd_in.last;
    rd_out.laddr <= rd_in.laddr;
    rd_out.waddr <= rd_in.waddr;
    // tags follow the data through read and multiply
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      psum_out.valid <= 1'b0;
      rd_out.valid <= 1'b0;
    end else begin
      tag1 <= {rd_in.valid, rd_in.first, rd_in.last};
      tag2 <= tag1;
      psum_out.valid <= tag2[2];
      rd_out.valid <= rd_in.valid;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/multichannel_valid_conv2d.sv]
// multichannel_valid_conv2d: top level, stream ports, position tracking,
// window sequencer and result register; uses mcv_pkg and mcv_cell
//
// Weight loads and image samples that complete no window leave the input ready.
// A sample that completes a KxK window starts a window pass: the sequencer
// issues the K*K kernel taps one per cycle into a chain of one cell per
// channel, and the tap sum leaves the chain through the read, multiply and
// sum registers of each cell, so the input is held until the result is
// loaded. The result then sits in the output register while new items are
// accepted. The one-tap-per-cycle issue of a window is set by the single
// read port of each cell's line store. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_valid_conv2d (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // sample_value, weight_row, weight_col, weight_channel
  input  wire logic [0:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // conv_value, out_row, out_col, zero fill
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int NC = mcv_pkg::MAX_CHANNELS;

  mcv_pkg::mcv_state_t state, state_next;

  logic [mcv_pkg::NREG_W-1:0] n_reg, n_eff;
  logic [mcv_pkg::KREG_W-1:0] k_reg, k_eff;
  logic [mcv_pkg::CREG_W-1:0] c_reg, c_eff;

  logic [mcv_pkg::COL_W-1:0]  prow, pcol;
  logic [mcv_pkg::CHI_W-1:0]  pch;
  logic [mcv_pkg::SLOT_W-1:0] pslot;
  logic [mcv_pkg::COL_W-1:0]  cur_row, cur_col;
  logic [mcv_pkg::CHI_W-1:0]  cur_ch;
  logic [mcv_pkg::SLOT_W-1:0] cur_slot;
  logic                       in_range;

  logic                              accept, is_sample, trigger;
  logic signed [mcv_pkg::DATA_W-1:0] s_val;
  logic [2:0]                        w_row, w_col;
  logic [mcv_pkg::CHI_W-1:0]         w_ch;
  logic [mcv_pkg::NREG_W-1:0]        r0_w, c0_w;
  logic [mcv_pkg::SLOT_W-1:0]        r0_slot;

  // window sequencer
  logic [mcv_pkg::SLOT_W-1:0]  win_slot, ri, jc;
  logic [mcv_pkg::COL_W-1:0]   win_c0;
  logic [mcv_pkg::WADDR_W-1:0] wrow_base;
  logic [mcv_pkg::KREG_W-1:0]  win_k;
  logic [mcv_pkg::COL_W-1:0]   res_row, res_col;
  logic                        res_last, done;
  logic signed [mcv_pkg::ACC_W-1:0] acc;

  mcv_pkg::mcv_rd_t  rd [NC+1];
  mcv_pkg::mcv_sum_t ps [NC+1];
  mcv_pkg::mcv_wr_t  wr [NC];

  // effective register values
  always_comb begin
    n_eff = (n_reg == '0) ? mcv_pkg::NREG_W'(1) :
            (n_reg > mcv_pkg::NREG_W'(mcv_pkg::MAX_IMAGE)) ?
            mcv_pkg::NREG_W'(mcv_pkg::MAX_IMAGE) : n_reg;
    k_eff = (k_reg == '0) ? mcv_pkg::KREG_W'(1) :
            (k_reg > mcv_pkg::KREG_W'(mcv_pkg::MAX_KERNEL)) ?
            mcv_pkg::KREG_W'(mcv_pkg::MAX_KERNEL) : k_reg;
    c_eff = (c_reg == '0) ? mcv_pkg::CREG_W'(1) :
            (c_reg > mcv_pkg::CREG_W'(mcv_pkg::MAX_CHANNELS)) ?
            mcv_pkg::CREG_W'(mcv_pkg::MAX_CHANNELS) : c_reg;
  end

  // input fields and current position
  assign s_val     = s_tdata[15:0];
  assign w_row     = s_tdata[18:16];
  assign w_col     = s_tdata[21:19];
  assign w_ch      = s_tdata[22 +: mcv_pkg::CHI_W];
  assign s_tready  = (state == mcv_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign is_sample = s_tuser[0];

  always_comb begin
    in_range = ({1'b0, prow} < n_eff) && ({1'b0, pcol} < n_eff) &&
               (mcv_pkg::CREG_W'(pch) < c_eff);
    cur_row  = in_range ? prow : '0;
    cur_col  = in_range ? pcol : '0;
    cur_ch   = in_range ? pch : '0;
    cur_slot = in_range ? pslot : '0;
    r0_w     = mcv_pkg::NREG_W'(cur_row) + 7'd1 - mcv_pkg::NREG_W'(k_eff);
    c0_w     = mcv_pkg::NREG_W'(cur_col) + 7'd1 - mcv_pkg::NREG_W'(k_eff);
    trigger  = (mcv_pkg::CREG_W'(cur_ch) == c_eff - 3'd1) &&
               (mcv_pkg::NREG_W'(k_eff) <= n_eff) &&
               (mcv_pkg::NREG_W'(cur_row) + 7'd1 >= mcv_pkg::NREG_W'(k_eff)) &&
               (mcv_pkg::NREG_W'(cur_col) + 7'd1 >= mcv_pkg::NREG_W'(k_eff));
    if (mcv_pkg::KREG_W'(cur_slot) >= k_eff - 3'd1)
      r0_slot = cur_slot - mcv_pkg::SLOT_W'(k_eff - 3'd1);
    else
      r0_slot = cur_slot + mcv_pkg::SLOT_W'(mcv_pkg::MAX_KERNEL) -
                mcv_pkg::SLOT_W'(k_eff - 3'd1);
  end

  // per-cell store writes
  always_comb begin
    for (int g = 0; g < NC; g++) begin
      wr[g].line_we = accept && is_sample && (cur_ch == mcv_pkg::CHI_W'(g));
      wr[g].laddr   = mcv_pkg::LADDR_W'(cur_slot) *
                      mcv_pkg::LADDR_W'(mcv_pkg::MAX_IMAGE) +
                      mcv_pkg::LADDR_W'(cur_col);
      wr[g].wt_we   = accept && !is_sample && (w_ch == mcv_pkg::CHI_W'(g)) &&
                      (w_row < 3'(mcv_pkg::MAX_KERNEL)) &&
                      (w_col < 3'(mcv_pkg::MAX_KERNEL));
      wr[g].waddr   = mcv_pkg::WADDR_W'(w_row) *
                      mcv_pkg::WADDR_W'(mcv_pkg::MAX_KERNEL) +
                      mcv_pkg::WADDR_W'(w_col);
      wr[g].data    = s_val;
    end
  end

  // configuration registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= mcv_pkg::NREG_W'(64);
      k_reg <= mcv_pkg::KREG_W'(3);
      c_reg <= mcv_pkg::CREG_W'(1);
      prow <= '0;
      pcol <= '0;
      pch <= '0;
      pslot <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcv_pkg::REG_IMAGE:   n_reg <= cfg_data;
        mcv_pkg::REG_KERNEL:  k_reg <= cfg_data[2:0];
        mcv_pkg::REG_CHANNEL: c_reg <= cfg_data[2:0];
        default: ;
      endcase
      if (cfg_index == mcv_pkg::REG_IMAGE || cfg_index == mcv_pkg::REG_KERNEL ||
          cfg_index == mcv_pkg::REG_CHANNEL) begin
        prow <= '0;
        pcol <= '0;
        pch <= '0;
        pslot <= '0;
      end
    end else if (accept && is_sample) begin
      if (mcv_pkg::CREG_W'(cur_ch) + 3'd1 >= c_eff) begin
        pch <= '0;
        if (mcv_pkg::NREG_W'(cur_col) + 7'd1 >= n_eff) begin
          pcol <= '0;
          if (mcv_pkg::NREG_W'(cur_row) + 7'd1 >= n_eff) begin
            prow <= '0;
            pslot <= '0;
          end else begin
            prow <= cur_row + 1'b1;
            pslot <= (cur_slot == mcv_pkg::SLOT_W'(mcv_pkg::MAX_KERNEL - 1)) ?
                     '0 : cur_slot + 1'b1;
          end
        end else begin
          pcol <= cur_col + 1'b1;
          prow <= cur_row;
          pslot <= cur_slot;
        end
      end else begin
        pch <= cur_ch + 1'b1;
        pcol <= cur_col;
        prow <= cur_row;
        pslot <= cur_slot;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= mcv_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mcv_pkg::ST_IDLE: if (accept && is_sample && trigger) state_next = mcv_pkg::ST_RUN;
      mcv_pkg::ST_RUN:  if (ri == win_k - 3'd1 && jc == win_k - 3'd1)
        state_next = mcv_pkg::ST_WAIT;
      mcv_pkg::ST_WAIT: if (done && (!m_tvalid || m_tready)) state_next = mcv_pkg::ST_IDLE;
      default: state_next = mcv_pkg::ST_IDLE;
    endcase
  end

  // tap counters of the window pass
  always_ff @(posedge clk) begin
    if (state == mcv_pkg::ST_IDLE && accept && is_sample && trigger) begin
      win_slot  <= r0_slot;
      win_c0    <= c0_w[mcv_pkg::COL_W-1:0];
      win_k     <= k_eff;
      res_row   <= r0_w[mcv_pkg::COL_W-1:0];
      res_col   <= c0_w[mcv_pkg::COL_W-1:0];
      res_last  <= (r0_w == n_eff - mcv_pkg::NREG_W'(k_eff)) &&
                   (c0_w == n_eff - mcv_pkg::NREG_W'(k_eff));
      ri        <= '0;
      jc        <= '0;
      wrow_base <= '0;
    end else if (state == mcv_pkg::ST_RUN) begin
      if (jc == win_k - 3'd1) begin
        jc <= '0;
        ri <= ri + 1'b1;
        wrow_base <= wrow_base + mcv_pkg::WADDR_W'(mcv_pkg::MAX_KERNEL);
        win_slot <= (win_slot == mcv_pkg::SLOT_W'(mcv_pkg::MAX_KERNEL - 1)) ?
                    '0 : win_slot + 1'b1;
      end else begin
        jc <= jc + 1'b1;
      end
    end
  end

  // request into the head of the chain
  always_comb begin
    rd[0].valid = (state == mcv_pkg::ST_RUN);
    rd[0].first = (ri == '0) && (jc == '0);
    rd[0].last  = (ri == win_k - 3'd1) && (jc == win_k - 3'd1);
    rd[0].laddr = mcv_pkg::LADDR_W'(win_slot) * mcv_pkg::LADDR_W'(mcv_pkg::MAX_IMAGE) +
                  mcv_pkg::LADDR_W'(win_c0 + mcv_pkg::COL_W'(jc));
    rd[0].waddr = wrow_base + mcv_pkg::WADDR_W'(jc);
    ps[0] = '0;
  end

  // one cell per channel
  for (genvar g = 0; g < NC; g++) begin : g_cell
    mcv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr[g]),
      .active   (mcv_pkg::CREG_W'(g) < c_eff),
      .rd_in    (rd[g]),
      .rd_out   (rd[g+1]),
      .psum_in  (ps[g]),
      .psum_out (ps[g+1])
    );
  end

  // tap accumulation at the tail of the chain
  always_ff @(posedge clk) begin
    if (ps[NC].valid)
      acc <= ps[NC].first ? mcv_pkg::ACC_W'(ps[NC].sum) :
             acc + mcv_pkg::ACC_W'(ps[NC].sum);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else if (ps[NC].valid && ps[NC].last) done <= 1'b1;
    else if (state == mcv_pkg::ST_WAIT && done && (!m_tvalid || m_tready)) done <= 1'b0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mcv_pkg::ST_WAIT && done && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcv_pkg::ST_WAIT && done && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0, res_col, res_row, mcv_pkg::CONV_W'(acc)};
      m_tlast <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != mcv_pkg::ST_IDLE |-> !s_tready)
    else $error("input accepted during a window pass");
  a_tail_in_pass: assert property (@(posedge clk) disable iff (rst)
    ps[NC].valid |-> state == mcv_pkg::ST_WAIT || state == mcv_pkg::ST_RUN)
    else $error("chain output outside a window pass");
  a_result_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == mcv_pkg::ST_WAIT && $past(done))
    else $error("result loaded without a finished window");
`endif

endmodule
`default_nettype wire
